FILE: sv/ordered_list_table_assert.svh
// Assertion macros for the ordered list table.
// Each takes a label, an antecedent and a consequent; clk and rst_n come
// from the module that uses them.
`ifndef ORDERED_LIST_TABLE_ASSERT_SVH
`define ORDERED_LIST_TABLE_ASSERT_SVH

`ifndef SYNTHESIS
`define OLT_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("ordered_list_table: same-cycle check failed");
`define OLT_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("ordered_list_table: next-cycle check failed");
`else
`define OLT_ASSERT_IMP(lbl, ante, cons)
`define OLT_ASSERT_NXT(lbl, ante, cons)
`endif

`endif

FILE: sv/olt_pkg.sv
package olt_pkg;

  localparam int CAPACITY   = 16;
  localparam int CNT_W      = $clog2(CAPACITY + 1);
  localparam int IDX_W      = $clog2(CAPACITY);
  localparam int VAL_W      = 32;
  localparam int OUT_CNT_W  = 5;
  localparam int CFG_IDX_W  = 8;
  localparam int CFG_DATA_W = 32;

  typedef logic [1:0] status_t;
  localparam status_t ST_DONE     = 2'd0;
  localparam status_t ST_DUP      = 2'd1;
  localparam status_t ST_NOTFOUND = 2'd2;
  localparam status_t ST_FULL     = 2'd3;

  localparam logic REQ_INSERT = 1'b0;
  localparam logic REQ_REMOVE = 1'b1;

  localparam logic [CFG_IDX_W-1:0] REG_SORTED_MODE = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_ALLOW_DUP   = CFG_IDX_W'(1);

  // one read and one write port request per cycle
  typedef struct packed {
    logic             we;
    logic [IDX_W-1:0] waddr;
    logic [VAL_W-1:0] wdata;
    logic             re;
    logic [IDX_W-1:0] raddr;
  } mem_req_t;

endpackage

FILE: sv/olt_ifs.sv
interface olt_in_if;
  import olt_pkg::*;
  logic             valid;
  logic             ready;
  logic             req_type;
  logic [VAL_W-1:0] value;
  modport source (output valid, output req_type, output value, input ready);
  modport sink (input valid, input req_type, input value, output ready);
endinterface

interface olt_out_if;
  import olt_pkg::*;
  logic                 valid;
  logic                 ready;
  status_t              status;
  logic [OUT_CNT_W-1:0] entry_count;
  logic                 is_empty;
  modport source (output valid, output status, output entry_count, output is_empty,
                  input ready);
  modport sink (input valid, input status, input entry_count, input is_empty,
                output ready);
endinterface

interface olt_cfg_if;
  import olt_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  idx;
  logic [CFG_DATA_W-1:0] data;
  modport source (output valid, output idx, output data, input ready);
  modport sink (input valid, input idx, input data, output ready);
endinterface

FILE: sv/olt_mem.sv
module olt_mem (
  input  logic                     clk,
  input  olt_pkg::mem_req_t        req,
  output logic [olt_pkg::VAL_W-1:0] rd_data_r
);
  import olt_pkg::*;

  logic [VAL_W-1:0] mem [CAPACITY];

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
    if (req.re) begin
      rd_data_r <= mem[req.raddr];
    end
  end

endmodule

FILE: sv/ordered_list_table.sv
// Sequence: a scan reads all N words, N being the entries held before the request; a move
// shifts up to N words; then come the slot write and the result register. The longest
// requests are a remove at the head of a full list and an insert at the head with one slot
// free. Throughput: one request in flight; the next input beat is taken while a result
// waits. Reset: synchronous, active low; list empty, sorted_mode = 0, allow_duplicates = 1.
`include "ordered_list_table_assert.svh"

module ordered_list_table (
  input logic clk,
  input logic rst_n,
  olt_in_if.sink    in_ch,
  olt_out_if.source out_ch,
  olt_cfg_if.sink   cfg_ch
);
  import olt_pkg::*;

  // one-hot sequencer
  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_SCAN  = 5'b00010,
    S_SHIFT = 5'b00100,
    S_WRITE = 5'b01000,
    S_RESP  = 5'b10000
  } state_t;

  state_t state_r, state_nxt;

  // control state
  logic             sorted_r, sorted_nxt;
  logic             adup_r, adup_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;      // entries held
  logic             pend_r, pend_nxt;    // a read is in flight
  logic             found_r, found_nxt;  // an equal entry was seen
  logic             ge_r, ge_nxt;        // an entry not below the value was seen
  logic             out_valid_r, out_valid_nxt;

  // payload
  logic                 op_r, op_nxt;
  logic [VAL_W-1:0]     val_r, val_nxt;
  logic [CNT_W-1:0]     idx_r, idx_nxt;     // next scan address
  logic [CNT_W-1:0]     pidx_r, pidx_nxt;   // address of the word in rd_data
  logic [CNT_W-1:0]     fidx_r, fidx_nxt;   // first equal entry
  logic [CNT_W-1:0]     gidx_r, gidx_nxt;   // first entry >= value
  logic [CNT_W-1:0]     pos_r, pos_nxt;     // insert slot
  logic [CNT_W-1:0]     sh_r, sh_nxt;       // move cursor
  logic [CNT_W-1:0]     pdst_r, pdst_nxt;   // destination of the word in flight
  status_t              st_r, st_nxt;
  status_t              ostat_r, ostat_nxt;
  logic [OUT_CNT_W-1:0] ocnt_r, ocnt_nxt;
  logic                 oempty_r, oempty_nxt;

  mem_req_t         mreq;
  logic [VAL_W-1:0] rd_data;
  logic [CNT_W-1:0] sh_dec, sh_inc;
  logic             in_beat, out_beat;
  logic             rd_eq, rd_lt;

  olt_mem u_mem (
    .clk       (clk),
    .req       (mreq),
    .rd_data_r (rd_data)
  );

  assign in_beat  = in_ch.valid && in_ch.ready;
  assign out_beat = out_valid_r && out_ch.ready;
  assign sh_dec   = sh_r - CNT_W'(1);
  assign sh_inc   = sh_r + CNT_W'(1);
  assign rd_eq    = (rd_data == val_r);
  assign rd_lt    = ($signed(rd_data) < $signed(val_r));

  // Input is taken only between requests; a held result does not block it.
  assign in_ch.ready  = (state_r == S_IDLE);
  assign cfg_ch.ready = 1'b1;

  assign out_ch.valid       = out_valid_r;
  assign out_ch.status      = ostat_r;
  assign out_ch.entry_count = ocnt_r;
  assign out_ch.is_empty    = oempty_r;

  always_comb begin
    state_nxt     = state_r;
    sorted_nxt    = sorted_r;
    adup_nxt      = adup_r;
    cnt_nxt       = cnt_r;
    pend_nxt      = pend_r;
    found_nxt     = found_r;
    ge_nxt        = ge_r;
    out_valid_nxt = out_valid_r;
    op_nxt        = op_r;
    val_nxt       = val_r;
    idx_nxt       = idx_r;
    pidx_nxt      = pidx_r;
    fidx_nxt      = fidx_r;
    gidx_nxt      = gidx_r;
    pos_nxt       = pos_r;
    sh_nxt        = sh_r;
    pdst_nxt      = pdst_r;
    st_nxt        = st_r;
    ostat_nxt     = ostat_r;
    ocnt_nxt      = ocnt_r;
    oempty_nxt    = oempty_r;
    mreq          = '0;

    if (out_beat) begin
      out_valid_nxt = 1'b0;
    end

    // register writes are for the user to make only while idle; the block does not enforce it
    if (cfg_ch.valid) begin
      unique case (cfg_ch.idx)
        REG_SORTED_MODE: sorted_nxt = cfg_ch.data[0];
        REG_ALLOW_DUP:   adup_nxt   = cfg_ch.data[0];
        default: ;
      endcase
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_beat) begin
          op_nxt    = in_ch.req_type;
          val_nxt   = in_ch.value;
          idx_nxt   = '0;
          pend_nxt  = 1'b0;
          found_nxt = 1'b0;
          ge_nxt    = 1'b0;
          st_nxt    = ST_DONE;
          state_nxt = S_SCAN;
        end
      end

      // Full pass from the head: first equal entry and first entry not
      // below the value. One read issued and one word checked per cycle.
      S_SCAN: begin
        if (pend_r) begin
          if (rd_eq && !found_r) begin
            found_nxt = 1'b1;
            fidx_nxt  = pidx_r;
          end
          if (!rd_lt && !ge_r) begin
            ge_nxt   = 1'b1;
            gidx_nxt = pidx_r;
          end
        end
        if (idx_r < cnt_r) begin
          mreq.re  = 1'b1;
          mreq.raddr = idx_r[IDX_W-1:0];
          idx_nxt  = idx_r + CNT_W'(1);
          pidx_nxt = idx_r;
          pend_nxt = 1'b1;
        end else begin
          pend_nxt = 1'b0;
          if (!pend_r) begin
            if (op_r == REQ_INSERT) begin
              if (!adup_r && found_r) begin
                st_nxt    = ST_DUP;
                state_nxt = S_RESP;
              end else if (cnt_r == CNT_W'(CAPACITY)) begin
                st_nxt    = ST_FULL;
                state_nxt = S_RESP;
              end else begin
                if (!sorted_r) begin
                  pos_nxt = '0;
                end else if (ge_r) begin
                  pos_nxt = gidx_r;
                end else begin
                  pos_nxt = cnt_r;
                end
                sh_nxt    = cnt_r;
                state_nxt = S_SHIFT;
              end
            end else begin
              if (!found_r) begin
                st_nxt    = ST_NOTFOUND;
                state_nxt = S_RESP;
              end else begin
                sh_nxt    = fidx_r;
                state_nxt = S_SHIFT;
              end
            end
          end
        end
      end

      // Move entries one slot: toward the tail for insert, toward the head
      // for remove. Read of the next source overlaps the write of the last.
      S_SHIFT: begin
        if (pend_r) begin
          mreq.we    = 1'b1;
          mreq.waddr = pdst_r[IDX_W-1:0];
          mreq.wdata = rd_data;
        end
        pend_nxt = 1'b0;
        if (op_r == REQ_INSERT) begin
          if (sh_r > pos_r) begin
            mreq.re    = 1'b1;
            mreq.raddr = sh_dec[IDX_W-1:0];
            pdst_nxt   = sh_r;
            sh_nxt     = sh_dec;
            pend_nxt   = 1'b1;
          end else if (!pend_r) begin
            state_nxt = S_WRITE;
          end
        end else begin
          if (sh_inc < cnt_r) begin
            mreq.re    = 1'b1;
            mreq.raddr = sh_inc[IDX_W-1:0];
            pdst_nxt   = sh_r;
            sh_nxt     = sh_inc;
            pend_nxt   = 1'b1;
          end else if (!pend_r) begin
            cnt_nxt   = cnt_r - CNT_W'(1);
            state_nxt = S_RESP;
          end
        end
      end

      S_WRITE: begin
        mreq.we    = 1'b1;
        mreq.waddr = pos_r[IDX_W-1:0];
        mreq.wdata = val_r;
        cnt_nxt    = cnt_r + CNT_W'(1);
        state_nxt  = S_RESP;
      end

      // wait for the output register to be free
      S_RESP: begin
        if (!out_valid_r || out_ch.ready) begin
          out_valid_nxt = 1'b1;
          ostat_nxt     = st_r;
          ocnt_nxt      = OUT_CNT_W'(cnt_r);
          oempty_nxt    = (cnt_r == '0);
          state_nxt     = S_IDLE;
        end
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      sorted_r    <= 1'b0;
      adup_r      <= 1'b1;
      cnt_r       <= '0;
      pend_r      <= 1'b0;
      found_r     <= 1'b0;
      ge_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      sorted_r    <= sorted_nxt;
      adup_r      <= adup_nxt;
      cnt_r       <= cnt_nxt;
      pend_r      <= pend_nxt;
      found_r     <= found_nxt;
      ge_r        <= ge_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r     <= op_nxt;
    val_r    <= val_nxt;
    idx_r    <= idx_nxt;
    pidx_r   <= pidx_nxt;
    fidx_r   <= fidx_nxt;
    gidx_r   <= gidx_nxt;
    pos_r    <= pos_nxt;
    sh_r     <= sh_nxt;
    pdst_r   <= pdst_nxt;
    st_r     <= st_nxt;
    ostat_r  <= ostat_nxt;
    ocnt_r   <= ocnt_nxt;
    oempty_r <= oempty_nxt;
  end

  // list never grows past its capacity
  `OLT_ASSERT_IMP(a_cnt_cap, 1'b1, cnt_r <= CNT_W'(CAPACITY))
  // a full report only ever comes with a full list
  `OLT_ASSERT_IMP(a_full_cnt, out_valid_r && (ostat_r == ST_FULL), ocnt_r == OUT_CNT_W'(CAPACITY))
  // an accepted request always starts with the head scan
  `OLT_ASSERT_NXT(a_start_scan, in_beat, state_r == S_SCAN)

endmodule
